// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher
package rc4_pkg;

  localparam int PermDepth = 256;
  localparam int KeyBytes  = 4;
  localparam int KeySelW   = $clog2(KeyBytes);

  // Datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL,
    OP_KS_RD_M,
    OP_KS_RD_J,
    OP_KS_WR_M,
    OP_KS_WR_J,
    OP_GEN_RD_I,
    OP_GEN_RD_J,
    OP_GEN_WR_I,
    OP_GEN_WR_J,
    OP_GEN_RD_T,
    OP_LOAD_OUT
  } op_t;

  // Commands from controller to datapath
  typedef struct packed {
    op_t  op;
    logic capture;   // latch the input beat
    logic start_ks;  // clear counter and both indices
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_last;  // schedule counter at its final position
    logic out_free;  // output register can take a beat this cycle
  } status_t;

endpackage

// ===== rtl/rc4_ctrl.sv =====
// Controller state machine for the RC4 stream cipher
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_M,
    ST_KS_RD_J,
    ST_KS_WR_M,
    ST_KS_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J,
    ST_GEN_RD_T,
    ST_GEN_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.capture  = 1'b0;
    cmd.start_ks = 1'b0;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = !rst;
        cmd.capture = s_tvalid && !rst;
        if (s_tvalid && !rst) begin
          if (s_tuser) begin
            cmd.start_ks = 1'b1;
            state_next   = ST_FILL;
          end else begin
            state_next = ST_GEN_RD_I;
          end
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (status.cnt_last) state_next = ST_KS_RD_M;
      end
      ST_KS_RD_M: begin
        cmd.op     = OP_KS_RD_M;
        state_next = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        cmd.op     = OP_KS_RD_J;
        state_next = ST_KS_WR_M;
      end
      ST_KS_WR_M: begin
        cmd.op     = OP_KS_WR_M;
        state_next = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        cmd.op     = OP_KS_WR_J;
        state_next = status.cnt_last ? ST_GEN_RD_I : ST_KS_RD_M;
      end
      ST_GEN_RD_I: begin
        cmd.op     = OP_GEN_RD_I;
        state_next = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        cmd.op     = OP_GEN_RD_J;
        state_next = ST_GEN_WR_I;
      end
      ST_GEN_WR_I: begin
        cmd.op     = OP_GEN_WR_I;
        state_next = ST_GEN_WR_J;
      end
      ST_GEN_WR_J: begin
        cmd.op     = OP_GEN_WR_J;
        state_next = ST_GEN_RD_T;
      end
      ST_GEN_RD_T: begin
        cmd.op     = OP_GEN_RD_T;
        state_next = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        // Hold the keystream byte until the output register frees up
        if (status.out_free) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rc4_dpath.sv =====
// Datapath for the RC4 stream cipher: permutation memory, indices, output register
module rc4_dpath
  import rc4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  logic [7:0]  mem [PermDepth];
  logic        wr_en;
  logic [7:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [7:0]  rd_addr;
  logic [7:0]  rd_data;

  logic [31:0] key;
  logic [7:0]  cnt;
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  logic [7:0]  sa;
  logic [7:0]  sb;
  logic [7:0]  text;
  logic        last;

  logic [7:0]  key_byte;
  logic [7:0]  i_next;
  logic [7:0]  j_ks_next;
  logic [7:0]  j_gen_next;

  assign key_byte   = key[8*cnt[KeySelW-1:0] +: 8];
  assign i_next     = idx_i + 8'd1;
  assign j_ks_next  = idx_j + rd_data + key_byte;
  assign j_gen_next = idx_j + rd_data;

  assign status.cnt_last = (cnt == 8'(PermDepth - 1));
  assign status.out_free = !m_tvalid || m_tready;

  // Drive memory port addresses from the current operation
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = cnt;
    rd_en   = 1'b0;
    rd_addr = cnt;
    unique case (cmd.op)
      OP_FILL: begin
        wr_en = 1'b1;
      end
      OP_KS_RD_M: begin
        rd_en = 1'b1;
      end
      OP_KS_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j_ks_next;
      end
      OP_KS_WR_M: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      OP_KS_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = sa;
      end
      OP_GEN_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_next;
      end
      OP_GEN_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j_gen_next;
      end
      OP_GEN_WR_I: begin
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = rd_data;
      end
      OP_GEN_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = sa;
      end
      OP_GEN_RD_T: begin
        rd_en   = 1'b1;
        rd_addr = sa + sb;
      end
      default: begin
      end
    endcase
  end

  // Permutation memory with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Key register
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      key <= cfg_data;
    end
  end

  // Indices and schedule counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      idx_i <= '0;
      idx_j <= '0;
    end else if (cmd.start_ks) begin
      cnt   <= '0;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      case (cmd.op)
        OP_FILL:     cnt   <= cnt + 8'd1;
        OP_KS_RD_J:  idx_j <= j_ks_next;
        OP_KS_WR_J: begin
          cnt <= cnt + 8'd1;
          if (status.cnt_last) idx_j <= '0;
        end
        OP_GEN_RD_I: idx_i <= i_next;
        OP_GEN_RD_J: idx_j <= j_gen_next;
        default: begin
        end
      endcase
    end
  end

  // Swap operands and captured input beat
  always_ff @(posedge clk) begin
    if (cmd.op == OP_KS_RD_J || cmd.op == OP_GEN_RD_J) sa <= rd_data;
    if (cmd.op == OP_GEN_WR_I) sb <= rd_data;
    if (cmd.capture) begin
      text <= s_tdata;
      last <= s_tlast;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_LOAD_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_OUT) begin
      m_tdata <= text ^ rd_data;
      m_tlast <= last;
    end
  end

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher, top level
// An ordinary byte passes read i, read j, write i, write j, read t and output
// states; output waits for a free output register. A beat with s_tuser set
// first runs the key schedule: a fill of all 256 entries, then a read m, read j,
// write m, write j step per entry. A new byte is taken only while idle.
// Reset: rst clears the key, both indices and the handshake state; memory holds.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tuser,   // first_of_message
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cipher_byte
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // key_word
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rc4_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== rtl/rc4_checker.sv =====
// Port-level checker for the RC4 stream cipher and its bind
`include "assert_macros.svh"

module rc4_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic s_beat;
  assign s_beat = s_tvalid && s_tready;

  // A stalled result beat holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // The block is busy right after taking a beat
  `ASSERT_NEXT(a_busy_after_beat, s_beat, !s_tready)

  // A new result appears only while the input side was closed
  `ASSERT_SAME(a_result_while_busy, $rose(m_tvalid), !$past(s_tready))

  // Configuration writes are always taken
  `ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
